// ===== sv/pce_pkg.sv =====
package pce_pkg;

  localparam int SYMBOL_COUNT  = 256;
  localparam int MAX_CODE_BITS = 32;
  localparam int LEN_LIMIT     = (MAX_CODE_BITS > 32) ? 32 : MAX_CODE_BITS;
  localparam int ADDR_W        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  localparam logic [7:0] TRAILER_BYTE = 8'h00;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  symbol;
    logic [5:0]  code_length;
    logic [31:0] code_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_item_t;

  typedef struct packed {
    logic table_we;
    logic rd_en;
    logic merge;
    logic emit;
    logic fin_first;
    logic fin_pad;
    logic clear;
  } pce_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       sym_ok;
    logic       total_ge8;
    logic       count_zero;
    logic       slot_free;
  } pce_stat_t;

endpackage

// ===== sv/pce_ctrl.sv =====
module pce_ctrl
  import pce_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pce_stat_t stat,
  output pce_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_EMIT = 3'd2;
  localparam logic [2:0] ST_FIN1 = 3'd3;
  localparam logic [2:0] ST_FIN2 = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (stat.command)
            CMD_LOAD: begin
              cmd.table_we = stat.sym_ok;
            end
            CMD_ENCODE: begin
              if (stat.sym_ok) begin
                cmd.rd_en = 1'b1;
                state_nxt = ST_READ;
              end
            end
            CMD_FINISH: begin
              state_nxt = ST_FIN1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.merge = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.total_ge8) begin
          state_nxt = ST_IDLE;
        end else if (stat.slot_free) begin
          cmd.emit = 1'b1;
        end
      end
      ST_FIN1: begin
        if (stat.slot_free) begin
          cmd.fin_first = 1'b1;
          if (stat.count_zero) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_FIN2;
          end
        end
      end
      ST_FIN2: begin
        if (stat.slot_free) begin
          cmd.fin_pad = 1'b1;
          cmd.clear   = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/pce_dp.sv =====
module pce_dp
  import pce_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data,
  input  pce_cmd_t  cmd,
  output pce_stat_t stat
);

  logic [37:0] table_mem [SYMBOL_COUNT];
  logic [37:0] rd_data_r;

  logic [6:0]  pend_r;
  logic [6:0]  pend_nxt;
  logic [2:0]  count_r;
  logic [2:0]  count_nxt;
  logic [39:0] acc_r;
  logic [39:0] acc_nxt;
  logic [5:0]  total_r;
  logic [5:0]  total_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_data_r;
  out_item_t   out_data_nxt;

  logic [5:0]  len_sat;
  logic [63:0] mask64;
  logic [31:0] code_masked;
  logic [5:0]  rd_len;
  logic [63:0] code_sh64;
  logic [39:0] acc_merge;

  always_comb begin
    len_sat     = (in_data.code_length > 6'(LEN_LIMIT)) ? 6'(LEN_LIMIT) : in_data.code_length;
    mask64      = (64'd1 << len_sat) - 64'd1;
    code_masked = in_data.code_bits & mask64[31:0];
    rd_len      = rd_data_r[37:32];
    code_sh64   = {32'd0, rd_data_r[31:0]} << (6'd32 - rd_len);
    acc_merge   = {pend_r, 33'd0} | ({code_sh64[31:0], 8'd0} >> count_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.table_we) begin
      table_mem[in_data.symbol[ADDR_W-1:0]] <= {len_sat, code_masked};
    end
    if (cmd.rd_en) begin
      rd_data_r <= table_mem[in_data.symbol[ADDR_W-1:0]];
    end
  end

  always_comb begin
    pend_nxt      = pend_r;
    count_nxt     = count_r;
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (cmd.merge) begin
      acc_nxt   = acc_merge;
      total_nxt = {3'd0, count_r} + rd_len;
    end
    if (cmd.emit) begin
      out_data_nxt  = '{out_byte: acc_r[39:32], last_byte: 1'b0};
      out_valid_nxt = 1'b1;
      acc_nxt       = {acc_r[31:0], 8'd0};
      total_nxt     = total_r - 6'd8;
    end
    if (cmd.merge || cmd.emit) begin
      pend_nxt  = acc_nxt[39:33];
      count_nxt = total_nxt[2:0];
    end
    if (cmd.fin_first) begin
      out_valid_nxt = 1'b1;
      if (count_r == 3'd0) begin
        out_data_nxt = '{out_byte: TRAILER_BYTE, last_byte: 1'b1};
      end else begin
        out_data_nxt = '{out_byte: {pend_r, 1'b0}, last_byte: 1'b0};
      end
    end
    if (cmd.fin_pad) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{out_byte: {4'd0, 4'd8 - {1'b0, count_r}}, last_byte: 1'b1};
    end
    if (cmd.clear) begin
      pend_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    total_r    <= total_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign stat.command    = in_data.command;
  assign stat.sym_ok     = ({1'b0, in_data.symbol} < 9'(SYMBOL_COUNT));
  assign stat.total_ge8  = (total_r >= 6'd8);
  assign stat.count_zero = (count_r == 3'd0);
  assign stat.slot_free  = !out_valid_r || !out_stall;

endmodule

// ===== sv/prefix_code_encoder.sv =====
// Channel  Direction  Payload     Handshake
// in_      input      in_item_t   in_valid / in_stall
// out_     output     out_item_t  out_valid / out_stall
//
// Load is taken in the idle state. Encode steps through table read, merge and
// final check, emitting output bytes while 8 or more bits are held, up to 4.
// Finish emits 1 or 2 bytes: a lone trailer, or padded bits and a pad count.
// The output register frees one byte per cycle; out_stall holds the controller.
// Reset clears the pending bits, bit count and output valid flag; the code table
// holds no valid state and must be loaded before use.
module prefix_code_encoder
  import pce_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  pce_cmd_t  cmd;
  pce_stat_t stat;

  pce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pce_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pce_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 32;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  prefix_code_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  logic [5:0]  code_len_mem [SYMBOL_COUNT];
  logic [31:0] code_val_mem [SYMBOL_COUNT];
  logic [6:0]  acc_bits;
  logic [2:0]  acc_count;
  out_item_t   coded_bytes_q [$];

  bit          sym_loaded [SYMBOL_COUNT];
  logic [7:0]  loaded_syms [$];

  int errors;
  int idle_cycles;
  int hold_req;
  int stall_left;
  int stall_roll;
  bit quiet_in;
  bit quiet_out;
  out_item_t expd;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic in_item_t make_item(logic [1:0] cmd, logic [7:0] sym,
                                         logic [5:0] len, logic [31:0] bits);
    in_item_t it;
    it.command     = cmd;
    it.symbol      = sym;
    it.code_length = len;
    it.code_bits   = bits;
    return it;
  endfunction

  function automatic void push_byte(logic [7:0] value, logic last);
    out_item_t r;
    r.out_byte  = value;
    r.last_byte = last;
    coded_bytes_q.push_back(r);
  endfunction

  function automatic void predict_bytes(in_item_t it);
    logic [63:0] acc;
    int          len;
    int          total;
    int          n;
    int          pad;
    n = 0;
    case (it.command)
      CMD_LOAD: begin
        if (int'(it.symbol) < SYMBOL_COUNT) begin
          len = (int'(it.code_length) > LEN_LIMIT) ? LEN_LIMIT : int'(it.code_length);
          code_len_mem[it.symbol] = len[5:0];
          code_val_mem[it.symbol] = it.code_bits & 32'(((64'd1 << len) - 64'd1));
        end
      end
      CMD_ENCODE: begin
        if (int'(it.symbol) < SYMBOL_COUNT) begin
          len = int'(code_len_mem[it.symbol]);
          if (len > 32) len = 32;
          acc = ({57'd0, acc_bits} << len) |
                ({32'd0, code_val_mem[it.symbol]} & ((64'd1 << len) - 64'd1));
          total = int'(acc_count) + len;
          while (total >= 8 && n < 4) begin
            push_byte(8'(acc >> (total - 8)), 1'b0);
            n++;
            total -= 8;
          end
          acc_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
          acc_count = 3'(total);
        end
      end
      CMD_FINISH: begin
        if (acc_count == 3'd0) begin
          push_byte(TRAILER_BYTE, 1'b1);
        end else begin
          pad = 8 - int'(acc_count);
          push_byte(8'({1'b0, acc_bits} << pad), 1'b0);
          push_byte(8'(pad), 1'b1);
        end
        acc_bits  = '0;
        acc_count = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_in || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [5:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 6'd0;
    if (r < 70) return 6'($urandom_range(1, 12));
    if (r < 90) return 6'($urandom_range(13, 32));
    return 6'($urandom_range(33, 63));
  endfunction

  function automatic in_item_t load_item(logic [7:0] sym);
    if (!sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
    return make_item(CMD_LOAD, sym, pick_length(), $urandom());
  endfunction

  function automatic in_item_t random_item();
    int r;
    logic [7:0] sym;
    r = $urandom_range(0, 99);
    if (r < 8) return load_item(8'($urandom_range(0, 255)));
    if (r < 88) begin
      sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
      return make_item(CMD_ENCODE, sym, 6'($urandom()), $urandom());
    end
    if (r < 95) return make_item(CMD_FINISH, 8'($urandom()), 6'($urandom()), $urandom());
    return make_item(CMD_UNUSED, 8'($urandom()), 6'($urandom()), $urandom());
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_bytes(it);
  endtask

  task automatic test_directed();
    send_item(load_item(8'd0));
    send_item(make_item(CMD_LOAD, 8'd0, 6'd0, 32'hFFFF_FFFF));
    send_item(load_item(8'd255));
    send_item(make_item(CMD_LOAD, 8'd255, 6'd32, 32'hFFFF_FFFF));
    send_item(load_item(8'd1));
    send_item(make_item(CMD_LOAD, 8'd1, 6'd1, 32'hFFFF_FFFE));
    send_item(load_item(8'd2));
    send_item(make_item(CMD_LOAD, 8'd2, 6'd63, 32'h1234_5678));
    send_item(load_item(8'd3));
    send_item(make_item(CMD_LOAD, 8'd3, 6'd33, 32'hA5A5_A5A5));
    send_item(load_item(8'd4));
    send_item(make_item(CMD_LOAD, 8'd4, 6'd7, 32'hFFFF_FF55));
    send_item(make_item(CMD_FINISH, 8'd0, 6'd0, 32'd0));
    send_item(make_item(CMD_ENCODE, 8'd0, 6'd0, 32'd0));
    send_item(make_item(CMD_ENCODE, 8'd255, 6'h3F, 32'hFFFF_FFFF));
    send_item(make_item(CMD_FINISH, 8'hFF, 6'h3F, 32'hFFFF_FFFF));
    send_item(make_item(CMD_ENCODE, 8'd1, 6'd0, 32'd0));
    send_item(make_item(CMD_ENCODE, 8'd4, 6'd0, 32'd0));
    send_item(make_item(CMD_ENCODE, 8'd2, 6'd0, 32'd0));
    send_item(make_item(CMD_ENCODE, 8'd3, 6'd0, 32'd0));
    send_item(make_item(CMD_FINISH, 8'd0, 6'd0, 32'd0));
    send_item(make_item(CMD_UNUSED, 8'hFF, 6'h3F, 32'hFFFF_FFFF));
    send_item(make_item(CMD_ENCODE, 8'd4, 6'd0, 32'd0));
    send_item(make_item(CMD_ENCODE, 8'd255, 6'd0, 32'd0));
    send_item(make_item(CMD_FINISH, 8'd0, 6'd0, 32'd0));
  endtask

  task automatic test_random_streams(int count);
    repeat (12) send_item(load_item(8'($urandom_range(0, 255))));
    repeat (count) send_item(random_item());
    send_item(make_item(CMD_FINISH, 8'($urandom()), 6'($urandom()), $urandom()));
  endtask

  task automatic test_backpressure();
    quiet_in = 1'b1;
    hold_req = 400;
    repeat (40) send_item(random_item());
    quiet_in = 1'b0;
  endtask

  task automatic test_no_idle(int count);
    quiet_in  = 1'b1;
    quiet_out = 1'b1;
    repeat (count) send_item(random_item());
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (quiet_out) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        out_stall <= 1'b0;
      end else begin
        if (stall_roll < 95) stall_left = $urandom_range(0, 2);
        else if (stall_roll < 99) stall_left = $urandom_range(3, 11);
        else stall_left = $urandom_range(29, 59);
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (coded_bytes_q.size() == 0) begin
        note_error($sformatf("unexpected byte %h last %b", out_data.out_byte,
                             out_data.last_byte));
      end else begin
        expd = coded_bytes_q.pop_front();
        if (out_data.out_byte !== expd.out_byte || out_data.last_byte !== expd.last_byte)
          note_error($sformatf("mismatch: expected byte %h last %b, got byte %h last %b",
                               expd.out_byte, expd.last_byte,
                               out_data.out_byte, out_data.last_byte));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    errors      = 0;
    idle_cycles = 0;
    hold_req    = 0;
    stall_left  = 0;
    quiet_in    = 1'b0;
    quiet_out   = 1'b0;
    acc_bits    = '0;
    acc_count   = '0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_streams(200);
    test_backpressure();
    test_no_idle(50);
    test_random_streams(20);

    in_valid <= 1'b0;
    while (coded_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pce_pkg.sv
sv/pce_ctrl.sv
sv/pce_dp.sv
sv/prefix_code_encoder.sv
tb/testbench.sv
